@@ hdl/vrbs_pkg.sv @@
// Shared types, constants and helpers of the volume render backward step unit.
package vrbs_pkg;

   // Fixed-point constants.
   localparam int unsigned ONE_Q16        = 65536;
   localparam int unsigned SAMPLE_CAP_DEF = 1048576;

   // Field widths.
   localparam int unsigned INDEX_W = 20;
   localparam int unsigned VAL_W   = 32;
   localparam int unsigned STEP_W  = 31;
   localparam int unsigned UNIT_W  = 17;

   // Request tdata layout, lowest bit first.
   localparam int unsigned REQ_IDX_LSB = 0;
   localparam int unsigned REQ_GR_LSB  = REQ_IDX_LSB + INDEX_W;
   localparam int unsigned REQ_GG_LSB  = REQ_GR_LSB + VAL_W;
   localparam int unsigned REQ_GB_LSB  = REQ_GG_LSB + VAL_W;
   localparam int unsigned REQ_DT_LSB  = REQ_GB_LSB + VAL_W;
   localparam int unsigned REQ_OP_LSB  = REQ_DT_LSB + STEP_W;
   localparam int unsigned REQ_WT_LSB  = REQ_OP_LSB + UNIT_W;
   localparam int unsigned REQ_TB_LSB  = REQ_WT_LSB + UNIT_W;
   localparam int unsigned REQ_CR_LSB  = REQ_TB_LSB + UNIT_W;
   localparam int unsigned REQ_CG_LSB  = REQ_CR_LSB + VAL_W;
   localparam int unsigned REQ_CB_LSB  = REQ_CG_LSB + VAL_W;
   localparam int unsigned REQ_USED_W  = REQ_CB_LSB + VAL_W;
   localparam int unsigned REQ_DATA_W  = ((REQ_USED_W + 7) / 8) * 8;

   // Response tdata layout, lowest bit first.
   localparam int unsigned RSP_IDX_LSB = 0;
   localparam int unsigned RSP_CR_LSB  = RSP_IDX_LSB + INDEX_W;
   localparam int unsigned RSP_CG_LSB  = RSP_CR_LSB + VAL_W;
   localparam int unsigned RSP_CB_LSB  = RSP_CG_LSB + VAL_W;
   localparam int unsigned RSP_DG_LSB  = RSP_CB_LSB + VAL_W;
   localparam int unsigned RSP_USED_W  = RSP_DG_LSB + VAL_W;
   localparam int unsigned RSP_DATA_W  = ((RSP_USED_W + 7) / 8) * 8;

   // Width that holds every intermediate before saturation.
   localparam int unsigned WIDE_W = 67;
   typedef logic signed [WIDE_W-1:0] wide_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_SUM,
      ST_MUL2,
      ST_RND,
      ST_DGM,
      ST_DGS
   } ctrl_state_type;

   // Stage strobes from the sequencer to the datapath.
   typedef struct packed {
      logic capture;
      logic mul1;
      logic sum;
      logic mul2;
      logic rnd;
      logic dgm;
      logic out_load;
   } vrbs_cmd_type;

   // Clamp a wide signed value to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input wide_type x);
      logic signed [31:0] res;
      if (x > wide_type'(64'sh0000_0000_7FFF_FFFF)) begin
         res = 32'sh7FFF_FFFF;
      end else if (x < wide_type'(-64'sh0000_0000_8000_0000)) begin
         res = 32'sh8000_0000;
      end else begin
         res = x[31:0];
      end
      return res;
   endfunction

   // Clamp a Q1.16 field to one.
   function automatic logic [UNIT_W-1:0] unit_clamp(input logic [UNIT_W-1:0] v);
      logic [UNIT_W-1:0] res;
      if (v > UNIT_W'(ONE_Q16)) begin
         res = UNIT_W'(ONE_Q16);
      end else begin
         res = v;
      end
      return res;
   endfunction

endpackage

@@ hdl/vrbs_ctrl.sv @@
// Sequencer of the volume render backward step unit: stage strobes and response valid.
module vrbs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output vrbs_pkg::vrbs_cmd_type cmd
);
   import vrbs_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // The output register can take a result when empty or when its beat leaves now.
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_MUL1;
         ST_MUL1: state_in = ST_SUM;
         ST_SUM:  state_in = ST_MUL2;
         ST_MUL2: state_in = ST_RND;
         ST_RND:  state_in = ST_DGM;
         ST_DGM:  state_in = ST_DGS;
         ST_DGS:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs: one strobe per stage.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_MUL1: cmd.mul1     = 1'b1;
         ST_SUM:  cmd.sum      = 1'b1;
         ST_MUL2: cmd.mul2     = 1'b1;
         ST_RND:  cmd.rnd      = 1'b1;
         ST_DGM:  cmd.dgm      = 1'b1;
         ST_DGS:  cmd.out_load = out_free;
         default: cmd          = '0;
      endcase
   end

   // Response valid flag.
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hdl/vrbs_datapath.sv @@
// Datapath of the volume render backward step unit: products, rounding and the adjoint.
module vrbs_datapath #(
   parameter int unsigned SAMPLE_CAP = vrbs_pkg::SAMPLE_CAP_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  vrbs_pkg::vrbs_cmd_type                cmd,
   input  logic                                  first_of_ray,
   input  logic [vrbs_pkg::INDEX_W-1:0]          sample_index,
   input  logic signed [vrbs_pkg::VAL_W-1:0]     image_grad_r,
   input  logic signed [vrbs_pkg::VAL_W-1:0]     image_grad_g,
   input  logic signed [vrbs_pkg::VAL_W-1:0]     image_grad_b,
   input  logic [vrbs_pkg::STEP_W-1:0]           step_length,
   input  logic [vrbs_pkg::UNIT_W-1:0]           opacity,
   input  logic [vrbs_pkg::UNIT_W-1:0]           blend_weight,
   input  logic [vrbs_pkg::UNIT_W-1:0]           trans_before,
   input  logic signed [vrbs_pkg::VAL_W-1:0]     color_r,
   input  logic signed [vrbs_pkg::VAL_W-1:0]     color_g,
   input  logic signed [vrbs_pkg::VAL_W-1:0]     color_b,
   output logic [vrbs_pkg::INDEX_W-1:0]          out_index,
   output logic signed [vrbs_pkg::VAL_W-1:0]     color_grad_r,
   output logic signed [vrbs_pkg::VAL_W-1:0]     color_grad_g,
   output logic signed [vrbs_pkg::VAL_W-1:0]     color_grad_b,
   output logic signed [vrbs_pkg::VAL_W-1:0]     density_grad
);
   import vrbs_pkg::*;

   // Captured beat.
   logic [INDEX_W-1:0]      idx_ff;
   logic                    oor_ff;
   logic signed [31:0]      g_ff [3];
   logic signed [31:0]      c_ff [3];
   logic [STEP_W-1:0]       dt_ff;
   logic [UNIT_W-1:0]       a_ff, w_ff, t_ff, oma_ff;
   logic signed [31:0]      adj_ff;
   logic [UNIT_W-1:0]       a_clamp;

   // Stage registers.
   logic signed [63:0]      pc_ff [3];
   logic signed [49:0]      pw_ff [3];
   logic [47:0]             pdt_ff;
   logic signed [31:0]      dot_ff;
   logic signed [31:0]      cg_ff [3];
   logic [31:0]             dads_ff;
   logic signed [49:0]      na_ff, nb_ff;
   logic signed [50:0]      paa_ff;
   logic signed [33:0]      aa_ff;
   logic signed [50:0]      plo_ff, phi_ff;
   logic signed [31:0]      adjoint_ff;

   // Output register.
   logic [INDEX_W-1:0]      out_index_ff;
   logic signed [31:0]      cgr_ff, cgg_ff, cgb_ff, dg_ff;

   // Combinational stage results.
   logic signed [63:0]      dot_raw;
   logic signed [49:0]      cg_rnd [3];
   logic [47:0]             dads_rnd;
   logic signed [32:0]      diff;
   logic signed [50:0]      nsum;
   logic signed [50:0]      aa_rnd;
   wide_type                full;
   logic signed [31:0]      dens_sat;

   assign a_clamp = unit_clamp(opacity);

   // Capture the accepted beat; the first sample of a ray starts from a zero adjoint.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff  <= sample_index;
         oor_ff  <= ({12'd0, sample_index} >= SAMPLE_CAP);
         g_ff[0] <= image_grad_r;
         g_ff[1] <= image_grad_g;
         g_ff[2] <= image_grad_b;
         c_ff[0] <= color_r;
         c_ff[1] <= color_g;
         c_ff[2] <= color_b;
         dt_ff   <= step_length;
         a_ff    <= a_clamp;
         oma_ff  <= UNIT_W'(ONE_Q16) - a_clamp;
         w_ff    <= unit_clamp(blend_weight);
         t_ff    <= unit_clamp(trans_before);
         adj_ff  <= first_of_ray ? 32'sd0 : adjoint_ff;
      end
   end

   // First products: colour dot terms, colour gradients and the step factor.
   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         for (int i = 0; i < 3; i++) begin
            pc_ff[i] <= g_ff[i] * c_ff[i];
            pw_ff[i] <= 50'(g_ff[i]) * 50'($signed({1'b0, w_ff}));
         end
         pdt_ff <= 48'(dt_ff) * 48'(oma_ff);
      end
   end

   // Round and sum the dot product, round the colour gradients and the step factor.
   always_comb begin
      dot_raw = 64'sd0;
      for (int i = 0; i < 3; i++) begin
         dot_raw   = dot_raw + ((pc_ff[i] + 64'sd32768) >>> 16);
         cg_rnd[i] = (pw_ff[i] + 50'sd32768) >>> 16;
      end
      dads_rnd = (pdt_ff + 48'd32768) >> 16;
   end

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         dot_ff  <= sat32(wide_type'(dot_raw));
         for (int i = 0; i < 3; i++) begin
            cg_ff[i] <= sat32(wide_type'(cg_rnd[i]));
         end
         dads_ff <= dads_rnd[31:0];
      end
   end

   // Second products: adjoint blend terms and the transmittance term.
   assign diff = 33'(dot_ff) - 33'(adj_ff);

   always_ff @(posedge clock) begin
      if (cmd.mul2) begin
         na_ff  <= 50'(dot_ff) * 50'($signed({1'b0, a_ff}));
         nb_ff  <= 50'(adj_ff) * 50'($signed({1'b0, oma_ff}));
         paa_ff <= 51'(diff) * 51'($signed({1'b0, t_ff}));
      end
   end

   // Round the blend into the adjoint and the transmittance term.
   assign nsum   = (51'(na_ff) + 51'(nb_ff) + 51'sd32768) >>> 16;
   assign aa_rnd = (paa_ff + 51'sd32768) >>> 16;

   always_ff @(posedge clock) begin
      if (reset) begin
         adjoint_ff <= 32'sd0;
      end else if (cmd.rnd && !oor_ff) begin
         adjoint_ff <= sat32(wide_type'(nsum));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rnd) begin
         aa_ff <= aa_rnd[33:0];
      end
   end

   // Density product in two 16-bit halves of the step factor.
   always_ff @(posedge clock) begin
      if (cmd.dgm) begin
         plo_ff <= 51'(aa_ff) * 51'($signed({1'b0, dads_ff[15:0]}));
         phi_ff <= 51'(aa_ff) * 51'($signed({1'b0, dads_ff[31:16]}));
      end
   end

   // Join the halves, round and saturate.
   assign full     = ((wide_type'(phi_ff) <<< 16) + wide_type'(plo_ff) + wide_type'(32768)) >>> 16;
   assign dens_sat = sat32(full);

   // Output register; an out-of-range index returns zero gradients.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_index_ff <= idx_ff;
         cgr_ff       <= oor_ff ? 32'sd0 : cg_ff[0];
         cgg_ff       <= oor_ff ? 32'sd0 : cg_ff[1];
         cgb_ff       <= oor_ff ? 32'sd0 : cg_ff[2];
         dg_ff        <= oor_ff ? 32'sd0 : dens_sat;
      end
   end

   assign out_index    = out_index_ff;
   assign color_grad_r = cgr_ff;
   assign color_grad_g = cgg_ff;
   assign color_grad_b = cgb_ff;
   assign density_grad = dg_ff;

endmodule

@@ hdl/volume_render_backward_step_unit.sv @@
// Volume render backward step unit: stream ports, field packing and the two sub-blocks.
//
// Usage: one ray sample enters per req beat, samples of a ray last sample first, with
// req_tuser high on the first beat of each ray (it clears the transmittance adjoint).
// Each request beat gives exactly one rsp beat carrying the sample index, the colour
// gradient and the density gradient, both gradients Q16.16 saturated.
// An accepted sample is captured, then passes the first multiply, sum, second multiply,
// adjoint round, split density multiply and output load states; a new request is taken
// only once the last sample has reached the output register. These stages share a single
// datapath, and the adjoint write at the end of each sample feeds the next.
// The output register parts the two sides: a new request is taken while a response
// beat still waits. When the receiver stalls, the next sample stops in its last stage
// until the output register frees, and req_tready stays low meanwhile.
// Reset clears the sequencer, the response valid flag and the adjoint to zero.
// Sample indices at or above the sample limit return zero gradients and leave the
// adjoint untouched.
module volume_render_backward_step_unit #(
   parameter int unsigned SAMPLE_CAP = vrbs_pkg::SAMPLE_CAP_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // sample_index, image_grad_r, image_grad_g, image_grad_b, step_length, opacity,
   // blend_weight, trans_before, color_r, color_g, color_b, zero pad
   input  logic [vrbs_pkg::REQ_DATA_W-1:0]     req_tdata,
   // first_of_ray
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_index, color_grad_r, color_grad_g, color_grad_b, density_grad, zero pad
   output logic [vrbs_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import vrbs_pkg::*;

   vrbs_cmd_type        cmd;
   logic [INDEX_W-1:0]  out_index;
   logic signed [31:0]  color_grad_r, color_grad_g, color_grad_b, density_grad;

   // Sequencer.
   vrbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // Datapath, fed with the unpacked request fields.
   vrbs_datapath #(
      .SAMPLE_CAP (SAMPLE_CAP)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .first_of_ray (req_tuser),
      .sample_index (req_tdata[REQ_IDX_LSB +: INDEX_W]),
      .image_grad_r ($signed(req_tdata[REQ_GR_LSB +: VAL_W])),
      .image_grad_g ($signed(req_tdata[REQ_GG_LSB +: VAL_W])),
      .image_grad_b ($signed(req_tdata[REQ_GB_LSB +: VAL_W])),
      .step_length  (req_tdata[REQ_DT_LSB +: STEP_W]),
      .opacity      (req_tdata[REQ_OP_LSB +: UNIT_W]),
      .blend_weight (req_tdata[REQ_WT_LSB +: UNIT_W]),
      .trans_before (req_tdata[REQ_TB_LSB +: UNIT_W]),
      .color_r      ($signed(req_tdata[REQ_CR_LSB +: VAL_W])),
      .color_g      ($signed(req_tdata[REQ_CG_LSB +: VAL_W])),
      .color_b      ($signed(req_tdata[REQ_CB_LSB +: VAL_W])),
      .out_index    (out_index),
      .color_grad_r (color_grad_r),
      .color_grad_g (color_grad_g),
      .color_grad_b (color_grad_b),
      .density_grad (density_grad)
   );

   // Pack the response beat.
   assign rsp_tdata = {(RSP_DATA_W - RSP_USED_W)'(0), density_grad, color_grad_b,
                       color_grad_g, color_grad_r, out_index};

endmodule

@@ verif/volume_render_backward_step_unit_test.sv @@
// Self-checking stream testbench for the volume render backward step unit.
`timescale 1ns / 100ps

module volume_render_backward_step_unit_test;
   import vrbs_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int LONG_HOLD   = 400;
   localparam int TAIL_CYCLES = 20;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
   localparam logic [30:0]        DT_MAX = 31'h7FFF_FFFF;

   // Wide enough for every product before rounding and clipping.
   typedef logic signed [95:0] ext_type;

   typedef struct packed {
      logic                first;
      logic [19:0]         idx;
      logic signed [31:0]  gr;
      logic signed [31:0]  gg;
      logic signed [31:0]  gb;
      logic [30:0]         dt;
      logic [16:0]         op;
      logic [16:0]         wt;
      logic [16:0]         tb;
      logic signed [31:0]  cr;
      logic signed [31:0]  cg;
      logic signed [31:0]  cb;
   } sample_type;

   typedef struct packed {
      logic [19:0]         idx;
      logic signed [31:0]  cgr;
      logic signed [31:0]  cgg;
      logic signed [31:0]  cgb;
      logic signed [31:0]  dgrad;
   } grad_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   sample_type pending_samples[$];
   grad_type   expected_grads[$];
   sample_type cur_sample;

   logic signed [31:0] trans_adj = '0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit want_long_hold = 1'b0;
   bit long_hold_done = 1'b0;
   int long_hold_count = 0;
   int quiet_cycles = 0;
   int mismatches = 0;
   int samples_sent = 0;
   int rays_seen = 0;
   int grads_checked = 0;

   volume_render_backward_step_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Round half up: add one half, then floor-shift by sixteen bits.
   function automatic ext_type round_q16(ext_type x);
      return (x + 32768) >>> 16;
   endfunction

   function automatic logic signed [31:0] clip32(ext_type x);
      if (x > ext_type'(Q_MAX)) return Q_MAX;
      if (x < ext_type'(Q_MIN)) return Q_MIN;
      return x[31:0];
   endfunction

   function automatic logic [16:0] limit_to_one(logic [16:0] v);
      return (v > 17'(ONE_Q16)) ? 17'(ONE_Q16) : v;
   endfunction

   // Gradients of one sample; for an in-range index, advances the transmittance adjoint as a side effect.
   function automatic grad_type backprop_sample(sample_type s);
      ext_type g0, g1, g2, c0, c1, c2, dot, adj, a, w, t, oma, dt, aa, dads;
      grad_type r;
      r = '0;
      r.idx = s.idx;
      if (s.idx >= SAMPLE_CAP_DEF) return r;
      g0 = s.gr;
      g1 = s.gg;
      g2 = s.gb;
      c0 = s.cr;
      c1 = s.cg;
      c2 = s.cb;
      dt = s.dt;
      a = limit_to_one(s.op);
      w = limit_to_one(s.wt);
      t = limit_to_one(s.tb);
      oma = 65536 - a;
      if (s.first) begin
         adj = 0;
      end else begin
         adj = trans_adj;
      end
      dot = clip32(round_q16(g0 * c0) + round_q16(g1 * c1) + round_q16(g2 * c2));
      r.cgr = clip32(round_q16(g0 * w));
      r.cgg = clip32(round_q16(g1 * w));
      r.cgb = clip32(round_q16(g2 * w));
      aa = round_q16((dot - adj) * t);
      dads = round_q16(dt * oma);
      r.dgrad = clip32(round_q16(aa * dads));
      trans_adj = clip32(round_q16(dot * a + adj * oma));
      return r;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_sample(sample_type s);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[REQ_IDX_LSB +: INDEX_W] = s.idx;
      d[REQ_GR_LSB +: VAL_W] = s.gr;
      d[REQ_GG_LSB +: VAL_W] = s.gg;
      d[REQ_GB_LSB +: VAL_W] = s.gb;
      d[REQ_DT_LSB +: STEP_W] = s.dt;
      d[REQ_OP_LSB +: UNIT_W] = s.op;
      d[REQ_WT_LSB +: UNIT_W] = s.wt;
      d[REQ_TB_LSB +: UNIT_W] = s.tb;
      d[REQ_CR_LSB +: VAL_W] = s.cr;
      d[REQ_CG_LSB +: VAL_W] = s.cg;
      d[REQ_CB_LSB +: VAL_W] = s.cb;
      return d;
   endfunction

   function automatic logic signed [31:0] rand_value();
      case ($urandom_range(9))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return '0;
         3, 4, 5: return $signed($urandom_range(0, 524288)) - 262144;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [16:0] rand_unit();
      case ($urandom_range(7))
         0: return 17'd0;
         1: return 17'(ONE_Q16);
         2: return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic logic [30:0] rand_step();
      case ($urandom_range(7))
         0: return '0;
         1: return DT_MAX;
         2: return 31'($urandom);
         default: return 31'($urandom_range(0, 262144));
      endcase
   endfunction

   task automatic add_sample(logic first, logic [19:0] idx,
                             logic signed [31:0] gr, logic signed [31:0] gg,
                             logic signed [31:0] gb, logic [30:0] dt,
                             logic [16:0] op, logic [16:0] wt, logic [16:0] tb,
                             logic signed [31:0] cr, logic signed [31:0] cg,
                             logic signed [31:0] cb);
      sample_type s;
      s = '{first, idx, gr, gg, gb, dt, op, wt, tb, cr, cg, cb};
      pending_samples.push_back(s);
   endtask

   // Mostly whole rays fed last sample first, with the odd misplaced ray flag
   // or a changed image gradient thrown in as noise.
   task automatic add_rays(int count);
      sample_type s;
      int len;
      int k;
      logic [19:0] base;
      while (count > 0) begin
         len = $urandom_range(1, 8);
         base = 20'($urandom);
         s.gr = rand_value();
         s.gg = rand_value();
         s.gb = rand_value();
         for (k = 0; k < len && count > 0; k++) begin
            s.first = (k == 0);
            if ($urandom_range(15) == 0) s.first = ~s.first;
            if ($urandom_range(31) == 0) s.gg = rand_value();
            s.idx = base - 20'(k);
            s.dt = rand_step();
            s.op = rand_unit();
            s.wt = rand_unit();
            s.tb = rand_unit();
            s.cr = rand_value();
            s.cg = rand_value();
            s.cb = rand_value();
            pending_samples.push_back(s);
            count--;
         end
      end
   endtask

   // Wait until every queued sample has been sent and every response checked,
   // including a beat still on offer.
   task automatic wait_drained();
      while (pending_samples.size() != 0 || req_tvalid || expected_grads.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(int send_pct, int recv_pct, int count, bit long_hold);
      @(negedge clock);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      if (long_hold) want_long_hold = 1'b1;
      add_rays(count);
      wait_drained();
   endtask

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Request driver: offers queued samples and predicts each accepted beat.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         trans_adj = '0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_grads.push_back(backprop_sample(cur_sample));
            samples_sent++;
            if (cur_sample.first) rays_seen++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_sample = pending_samples.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= pack_sample(cur_sample);
               req_tuser <= cur_sample.first;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response ready: random stalls, plus one long hold-off to back up the unit.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (want_long_hold && !long_hold_done) begin
         rsp_tready <= 1'b0;
         long_hold_count++;
         if (long_hold_count >= LONG_HOLD) long_hold_done = 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Response monitor: each beat is checked against the oldest prediction.
   always @(posedge clock) begin : rsp_monitor
      grad_type got;
      grad_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.idx = rsp_tdata[RSP_IDX_LSB +: INDEX_W];
         got.cgr = rsp_tdata[RSP_CR_LSB +: VAL_W];
         got.cgg = rsp_tdata[RSP_CG_LSB +: VAL_W];
         got.cgb = rsp_tdata[RSP_CB_LSB +: VAL_W];
         got.dgrad = rsp_tdata[RSP_DG_LSB +: VAL_W];
         if (expected_grads.size() == 0) begin
            $display("%0t: response beat with nothing expected, index %h", $time, got.idx);
            mismatches++;
         end else begin
            want = expected_grads.pop_front();
            compare_field("out_index", 32'(want.idx), 32'(got.idx));
            compare_field("color_grad_r", want.cgr, got.cgr);
            compare_field("color_grad_g", want.cgg, got.cgg);
            compare_field("color_grad_b", want.cgb, got.cgb);
            compare_field("density_grad", want.dgrad, got.dgrad);
            grads_checked++;
         end
      end
   end

   // Watchdog on cycles without any beat on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat for %0d cycles, %0d responses outstanding", $time,
                  QUIET_LIMIT, expected_grads.size());
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed samples: zeros, saturating dot products, clamped unit fields,
      // rounding at exactly one half, and adjoint carried along a ray.
      add_sample(1, 20'h0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_sample(1, 20'hFFFFF, Q_MAX, Q_MAX, Q_MAX, DT_MAX, 17'd65536, 17'd65536,
                 17'd65536, Q_MAX, Q_MAX, Q_MAX);
      add_sample(0, 20'h1, Q_MAX, Q_MAX, Q_MAX, DT_MAX, 17'd0, 17'd65536, 17'd65536,
                 Q_MIN, Q_MIN, Q_MIN);
      add_sample(0, 20'h2, Q_MIN, Q_MIN, Q_MIN, DT_MAX, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF,
                 Q_MIN, Q_MIN, Q_MIN);
      add_sample(0, 20'h3, Q_MIN, Q_MAX, 0, DT_MAX, 17'd65537, 17'd0, 17'd65537,
                 Q_MAX, Q_MIN, 0);
      add_sample(1, 20'h4, 1, -1, 3, 31'd1, 17'd32768, 17'd32768, 17'd32768, 1, -1, 1);
      add_sample(0, 20'h5, Q_ONE, -Q_ONE, Q_ONE / 2, 31'd65536, 17'd32768, 17'd32768,
                 17'd65536, Q_ONE / 2, Q_ONE, -Q_ONE);
      add_sample(1, 20'h8, 2 * Q_ONE, Q_ONE, Q_ONE, 31'd16384, 17'd16384, 17'd40000,
                 17'd50000, Q_ONE, Q_ONE, Q_ONE);
      add_sample(0, 20'h7, 2 * Q_ONE, Q_ONE, Q_ONE, 31'd16384, 17'd20000, 17'd30000,
                 17'd35000, -Q_ONE, Q_ONE / 4, 3 * Q_ONE);
      add_sample(0, 20'h6, 2 * Q_ONE, Q_ONE, Q_ONE, 31'd16384, 17'd65535, 17'd1,
                 17'd17000, 0, 0, 0);
      add_sample(0, 20'hAAAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F,
                 31'h2AAA_AAAA, 17'h0AAAA, 17'h05555, 17'h10000,
                 32'shAAAA_AAAA, 32'sh5555_5555, 32'shF0F0_F0F0);
      add_sample(0, 20'h55555, 0, 0, 0, DT_MAX, 17'd0, 17'd0, 17'd0, 0, 0, 0);
      run_phase(0, 0, 0, 1'b0);

      // Random rays under each idling pattern; the long hold-off runs while
      // the sender keeps offering at full rate.
      run_phase(0, 0, 275, 1'b1);
      run_phase(75, 0, 275, 1'b0);
      run_phase(0, 75, 275, 1'b0);
      run_phase(25, 25, 275, 1'b0);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_grads.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, expected_grads.size());
         mismatches++;
      end

      $display("Sent %0d samples in %0d rays, checked %0d responses, %0d mismatches.",
               samples_sent, rays_seen, grads_checked, mismatches);
      $display("Covered free-running, sender gaps, receiver stalls and a %0d-cycle hold-off.",
               LONG_HOLD);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
